// ===== rtl/sliding_window_min_max_unit_macros.svh =====
// Assertion macros for the sliding window min/max unit.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef SLIDING_WINDOW_MIN_MAX_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_UNIT_MACROS_SVH

// checked only outside reset
`define SWMM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SWMM_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/swmm_pkg.sv =====
// Shared types and constants for the sliding window min/max unit.
// No dependencies; used by swmm_cell, swmm_chain and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 11;

  // broadcast to every cell of a chain
  typedef struct packed {
    logic                     step;    // item accepted this cycle
    logic                     clear;   // restart: drop every entry
    logic                     trim;    // pop expired fronts, no item
    logic signed [DATA_W-1:0] sample;
  } swmm_ctl_t;

  // front of a chain as seen by the top level
  typedef struct packed {
    logic                     expired;
    logic signed [DATA_W-1:0] value_next;
  } swmm_front_t;

  typedef enum logic {
    ST_RUN,
    ST_TRIM
  } swmm_state_t;

endpackage

`default_nettype wire

// ===== rtl/swmm_cell.sv =====
// One cell of a monotonic queue chain: holds one entry (value, age, valid).
// Depends on swmm_pkg. Talks only to its left and right neighbours.
`timescale 1ns / 1ps
`default_nettype none

module swmm_cell #(
  parameter bit IS_MAX = 1'b0,
  parameter int AW     = 11
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire swmm_pkg::swmm_ctl_t               ctl,
  input  wire logic                              shift,
  input  wire logic                              left_post,
  input  wire logic                              rgt_valid,
  input  wire logic signed [swmm_pkg::DATA_W-1:0] rgt_value,
  input  wire logic [AW-1:0]                     rgt_age,
  output logic                                   valid,
  output logic signed [swmm_pkg::DATA_W-1:0]     value,
  output logic [AW-1:0]                          age,
  output logic                                   post_valid,
  output logic signed [swmm_pkg::DATA_W-1:0]     value_next
);

  logic                              sh_valid;
  logic signed [swmm_pkg::DATA_W-1:0] sh_value;
  logic [AW-1:0]                     sh_age;
  logic                              beaten;
  logic                              valid_next;
  logic [AW-1:0]                     age_next;

  always_comb begin
    // view after the front pop, if any
    sh_valid = shift ? rgt_valid : valid;
    sh_value = shift ? rgt_value : value;
    sh_age   = shift ? rgt_age   : age;
    if (IS_MAX) begin
      beaten = sh_value < ctl.sample;
    end else begin
      beaten = sh_value > ctl.sample;
    end
    post_valid = sh_valid && !(ctl.step && (ctl.clear || beaten));

    valid_next = valid;
    value_next = value;
    age_next   = age;
    if (ctl.step) begin
      if (post_valid) begin
        valid_next = 1'b1;
        value_next = sh_value;
        age_next   = sh_age + AW'(1);
      end else if (left_post) begin
        // first free slot behind the surviving entries takes the sample
        valid_next = 1'b1;
        value_next = ctl.sample;
        age_next   = AW'(1);
      end else begin
        valid_next = 1'b0;
      end
    end else if (shift) begin
      valid_next = sh_valid;
      value_next = sh_value;
      age_next   = sh_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age   <= age_next;
  end

endmodule

`default_nettype wire

// ===== rtl/swmm_chain.sv =====
// Row of swmm_cell forming one monotonic queue, front at cell 0.
// Depends on swmm_pkg and swmm_cell.
`timescale 1ns / 1ps
`default_nettype none

module swmm_chain #(
  parameter bit IS_MAX     = 1'b0,
  parameter int WINDOW_MAX = 1024,
  parameter int AW         = 11
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire swmm_pkg::swmm_ctl_t ctl,
  input  wire logic [AW-1:0]       win,
  output swmm_pkg::swmm_front_t    front
);

  logic                               cell_valid [WINDOW_MAX];
  logic signed [swmm_pkg::DATA_W-1:0] cell_value [WINDOW_MAX];
  logic [AW-1:0]                      cell_age   [WINDOW_MAX];
  logic                               cell_post  [WINDOW_MAX];
  logic signed [swmm_pkg::DATA_W-1:0] cell_next  [WINDOW_MAX];
  logic                               expired;
  logic                               shift;

  // age counts items since entry; the front leaves once it reaches the window
  assign expired = cell_valid[0] && (cell_age[0] >= win);
  assign shift   = expired && (ctl.step || ctl.trim);

  assign front.expired    = expired;
  assign front.value_next = cell_next[0];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                               r_valid;
    logic signed [swmm_pkg::DATA_W-1:0] r_value;
    logic [AW-1:0]                      r_age;
    logic                               l_post;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_age   = '0;
    end else begin : g_mid
      assign r_valid = cell_valid[i+1];
      assign r_value = cell_value[i+1];
      assign r_age   = cell_age[i+1];
    end

    if (i == 0) begin : g_first
      assign l_post = 1'b1;
    end else begin : g_rest
      assign l_post = cell_post[i-1];
    end

    swmm_cell #(
      .IS_MAX (IS_MAX),
      .AW     (AW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .shift      (shift),
      .left_post  (l_post),
      .rgt_valid  (r_valid),
      .rgt_value  (r_value),
      .rgt_age    (r_age),
      .valid      (cell_valid[i]),
      .value      (cell_value[i]),
      .age        (cell_age[i]),
      .post_valid (cell_post[i]),
      .value_next (cell_next[i])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_min_max_unit.sv =====
// Sliding window minimum / maximum unit.
// Usage:
//   s_axis: one signed 32-bit sample per item in tdata, restart flag in tuser.
//   m_axis: window minimum in tdata[31:0], maximum in tdata[63:32].
//   cfg:    window_length write (11 bits); 0 acts as 1, above WINDOW_MAX saturates.
// The result of an item is registered and is on m_axis in the cycle after it is accepted.
// Throughput: one item per cycle outside a trim and while m_axis is not stalled;
//   all cells of both chains compare with the new sample at once, so no item waits.
// A result appears only once window_length samples have arrived since reset
//   or the last restart; earlier items give none.
// After a window_length write s_axis_tready stays low while the queue fronts
//   are trimmed: entries too old for the new length (up to WINDOW_MAX) are
//   popped until both fronts are inside the window.
// Reset empties both queues, clears the fill count and sets window_length to 3.
// While m_axis stalls, a pending result holds and no new item is taken.
// Depends on swmm_pkg, swmm_chain, swmm_cell and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_min_max_unit_macros.svh"

module sliding_window_min_max_unit #(
  parameter int WINDOW_MAX = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [swmm_pkg::CFG_W-1:0]    cfg_data,     // window_length
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [swmm_pkg::DATA_W-1:0]   s_axis_tdata, // [31:0] sample
  input  wire logic                          s_axis_tuser, // [0] restart
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [2*swmm_pkg::DATA_W-1:0]      m_axis_tdata  // [31:0] min, [63:32] max
);

  localparam int AW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (AW > swmm_pkg::CFG_W) ? AW : swmm_pkg::CFG_W;

  logic [swmm_pkg::CFG_W-1:0] window_length;
  logic [CW-1:0]              wl_ext;
  logic [AW-1:0]              w_eff;
  logic [AW-1:0]              fill_count;
  logic [AW-1:0]              fill_next;
  logic                       cfg_acc;
  logic                       in_acc;
  logic                       has_result;
  logic                       trim;
  logic                       in_ready;
  swmm_pkg::swmm_state_t      state;
  swmm_pkg::swmm_state_t      state_next;
  swmm_pkg::swmm_ctl_t        ctl;
  swmm_pkg::swmm_front_t      min_front;
  swmm_pkg::swmm_front_t      max_front;

  assign cfg_ready     = 1'b1;
  assign cfg_acc       = cfg_valid && cfg_ready;
  assign s_axis_tready = in_ready;
  assign in_acc        = s_axis_tvalid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swmm_pkg::CFG_W'(3);
    end else if (cfg_acc) begin
      window_length <= cfg_data;
    end
  end

  always_comb begin
    wl_ext = CW'(window_length);
    if (wl_ext == '0) begin
      w_eff = AW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      w_eff = AW'(WINDOW_MAX);
    end else begin
      w_eff = AW'(wl_ext);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmm_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    trim       = 1'b0;
    in_ready   = 1'b0;
    case (state)
      swmm_pkg::ST_RUN: begin
        in_ready = !m_axis_tvalid || m_axis_tready;
        if (cfg_acc) begin
          state_next = swmm_pkg::ST_TRIM;
        end
      end
      swmm_pkg::ST_TRIM: begin
        trim = 1'b1;
        if (!cfg_acc && !min_front.expired && !max_front.expired) begin
          state_next = swmm_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = swmm_pkg::ST_RUN;
      end
    endcase
  end

  assign ctl.step   = in_acc;
  assign ctl.clear  = s_axis_tuser;
  assign ctl.trim   = trim;
  assign ctl.sample = $signed(s_axis_tdata);

  swmm_chain #(
    .IS_MAX     (1'b0),
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW)
  ) u_min_chain (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .win   (w_eff),
    .front (min_front)
  );

  swmm_chain #(
    .IS_MAX     (1'b1),
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW)
  ) u_max_chain (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .win   (w_eff),
    .front (max_front)
  );

  // fill count saturates at the deepest window
  always_comb begin
    if (s_axis_tuser) begin
      fill_next = AW'(1);
    end else if (fill_count == AW'(WINDOW_MAX)) begin
      fill_next = fill_count;
    end else begin
      fill_next = fill_count + AW'(1);
    end
  end

  assign has_result = fill_next >= w_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_count    <= fill_next;
        m_axis_tvalid <= has_result;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_result) begin
      m_axis_tdata <= {max_front.value_next, min_front.value_next};
    end
  end

  `SWMM_CHECK(a_no_item_in_trim, (state == swmm_pkg::ST_TRIM) |-> !s_axis_tready, "item taken during front trim")
  `SWMM_CHECK(a_restart_fill, (in_acc && s_axis_tuser) |=> (fill_count == AW'(1)), "restart did not reset fill count")
  `SWMM_CHECK(a_result_from_item, $rose(m_axis_tvalid) |-> $past(in_acc), "result without accepted item")
  `SWMM_CHECK_ALWAYS(a_reset_state, rst |=> (fill_count == '0 && !m_axis_tvalid), "reset left state behind")

endmodule

`default_nettype wire
